FILE: sv/rle_sprite_blend_decoder_assert.svh
// assertion macros for the rle sprite blend decoder
`ifndef RLE_SPRITE_BLEND_DECODER_ASSERT_SVH
`define RLE_SPRITE_BLEND_DECODER_ASSERT_SVH

// same-cycle implication, checked on every clock outside reset
`define RSBD_ASSERT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rsbd assertion failed");

// next-cycle implication
`define RSBD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rsbd assertion failed");

`endif

FILE: sv/rsbd_pkg.sv
// shared types, constants and blend function for the rle sprite blend decoder
`default_nettype none

package rsbd_pkg;

  localparam int ROW_PIXELS_DEF = 1024;

  localparam int WORD_W  = 16;
  localparam int COUNT_W = 13;
  localparam int KIND_W  = 3;
  localparam int COL_W   = 10;
  localparam int CHUNK_W = 7;
  localparam int MODE_W  = 2;

  localparam logic [WORD_W-1:0] MASK_HALF    = 16'hf7de;
  localparam logic [WORD_W-1:0] MASK_QUARTER = 16'he79c;

  localparam logic [KIND_W-1:0] KIND_SKIP = 3'd0;
  localparam logic [KIND_W-1:0] KIND_B25  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_B50  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_B75  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_COPY = 3'd4;
  localparam logic [KIND_W-1:0] KIND_PAD3 = 3'd5;

  localparam logic [MODE_W-1:0] MODE_DRAW    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SAVE    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_RESTORE = 2'd2;

  localparam logic REG_MODE   = 1'b0;
  localparam logic REG_CHUNKS = 1'b1;

  typedef enum logic [3:0] {
    PH_COUNT = 4'b0001,
    PH_CODE  = 4'b0010,
    PH_RUN   = 4'b0100,
    PH_PAD   = 4'b1000
  } phase_t;

  typedef struct packed {
    logic              pixel_write;
    logic [COL_W-1:0]  column;
    logic [WORD_W-1:0] pixel_value;
    logic              save_write;
    logic [WORD_W-1:0] saved_value;
    logic              row_done;
  } res_t;

  function automatic logic [WORD_W-1:0] blend(input logic [KIND_W-1:0] kind,
                                               input logic [WORD_W-1:0] d,
                                               input logic [WORD_W-1:0] s);
    logic [WORD_W+1:0] dq, sq, dh, sh, v;
    dq = {2'b00, d & MASK_QUARTER};
    sq = {2'b00, s & MASK_QUARTER};
    dh = {2'b00, d & MASK_HALF};
    sh = {2'b00, s & MASK_HALF};
    case (kind)
      KIND_B50: v = (dh + sh) >> 1;
      KIND_B25: v = (dq + dq + dq + sq) >> 2;
      KIND_B75: v = (dq + sq + sq + sq) >> 2;
      default:  v = {2'b00, s};
    endcase
    return v[WORD_W-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: sv/rle_sprite_blend_decoder.sv
// rle sprite blend decoder: one rgb565 sprite row, one stream word per beat
// input channel (in_valid/in_ready) carries row_start, stream_word, dest_pixel
// and stored_pixel; the output channel (out_valid/out_ready) returns exactly
// one result beat per input beat, in order.
// the decode state advances on the accepting edge; the result is registered
// into the output register, or into the skid register while one waits.
// throughput is one beat per cycle while in_ready is high, set by the
// single-pass decode logic between the input ports and the output register.
// a two-entry output stage (output register plus skid register) keeps the
// input open while one result waits; in_ready drops only when both are full,
// and a stalled receiver holds out_valid and the result steady.
// configuration goes through an apb-style port: operation_mode at address 0,
// chunks_per_row at address 4; write only while no beat is in flight.
// reset (synchronous, active high) empties the output stage, returns the
// decoder to waiting for a row_start, and sets mode draw with one chunk per row.
// words arriving with no open row are consumed and give an empty result.
`default_nettype none

module rle_sprite_blend_decoder #(
  parameter int ROW_PIXELS = rsbd_pkg::ROW_PIXELS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output      logic [31:0] prdata,
  output      logic        pready,
  input  wire logic        in_valid,
  output      logic        in_ready,
  input  wire logic        row_start,
  input  wire logic [15:0] stream_word,
  input  wire logic [15:0] dest_pixel,
  input  wire logic [15:0] stored_pixel,
  output      logic        out_valid,
  input  wire logic        out_ready,
  output      logic        pixel_write,
  output      logic [9:0]  column,
  output      logic [15:0] pixel_value,
  output      logic        save_write,
  output      logic [15:0] saved_value,
  output      logic        row_done
);

  localparam int CUR_W = $clog2(ROW_PIXELS + 1);
  localparam int SUM_W = ((CUR_W > rsbd_pkg::COUNT_W) ? CUR_W : rsbd_pkg::COUNT_W) + 1;

  // configuration registers
  logic [rsbd_pkg::MODE_W-1:0]  operation_mode;
  logic [rsbd_pkg::CHUNK_W-1:0] chunks_per_row;

  logic cfg_write;
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      operation_mode <= rsbd_pkg::MODE_DRAW;
      chunks_per_row <= rsbd_pkg::CHUNK_W'(1);
    end else if (cfg_write) begin
      case (paddr[2])
        rsbd_pkg::REG_MODE:   operation_mode <= pwdata[rsbd_pkg::MODE_W-1:0];
        rsbd_pkg::REG_CHUNKS: chunks_per_row <= pwdata[rsbd_pkg::CHUNK_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      rsbd_pkg::REG_MODE:   prdata = 32'(operation_mode);
      rsbd_pkg::REG_CHUNKS: prdata = 32'(chunks_per_row);
      default:              prdata = '0;
    endcase
  end

  // decode state
  rsbd_pkg::phase_t              phase, phase_next;
  logic [rsbd_pkg::CHUNK_W-1:0]  chunks_left, chunks_left_next;
  logic [rsbd_pkg::WORD_W-1:0]   codes_left, codes_left_next;
  logic [rsbd_pkg::COUNT_W-1:0]  run_left, run_left_next;
  logic [rsbd_pkg::KIND_W-1:0]   run_kind, run_kind_next;
  logic [CUR_W-1:0]              cursor, cursor_next;

  // output stage
  logic                out_full, skid_full;
  rsbd_pkg::res_t      out_res, skid_res, res;

  logic in_fire;
  assign in_ready = !skid_full;
  assign in_fire  = in_valid && in_ready;

  // state after an optional row restart
  rsbd_pkg::phase_t              s_phase;
  logic [rsbd_pkg::CHUNK_W-1:0]  s_chunks;
  logic [rsbd_pkg::WORD_W-1:0]   s_codes;
  logic [rsbd_pkg::COUNT_W-1:0]  s_run;
  logic [rsbd_pkg::KIND_W-1:0]   s_kind;
  logic [CUR_W-1:0]              s_cursor;

  logic [rsbd_pkg::KIND_W-1:0]   kind;
  logic [rsbd_pkg::COUNT_W-1:0]  count;
  logic [SUM_W-1:0]              skip_sum;
  logic [31:0]                   cur_ext;
  logic                          code_end, chunk_end;

  assign kind  = stream_word[15:13];
  assign count = stream_word[rsbd_pkg::COUNT_W-1:0];

  always_comb begin
    s_phase  = phase;
    s_chunks = chunks_left;
    s_codes  = codes_left;
    s_run    = run_left;
    s_kind   = run_kind;
    s_cursor = cursor;
    if (row_start) begin
      s_chunks = (chunks_per_row == '0) ? rsbd_pkg::CHUNK_W'(1) : chunks_per_row;
      s_phase  = rsbd_pkg::PH_COUNT;
      s_codes  = '0;
      s_run    = '0;
      s_kind   = '0;
      s_cursor = '0;
    end

    phase_next       = s_phase;
    chunks_left_next = s_chunks;
    codes_left_next  = s_codes;
    run_left_next    = s_run;
    run_kind_next    = s_kind;
    cursor_next      = s_cursor;
    code_end         = 1'b0;
    chunk_end        = 1'b0;
    res              = '0;
    skip_sum         = SUM_W'(s_cursor) + SUM_W'(count);
    cur_ext          = 32'(s_cursor);

    case (s_phase)
      rsbd_pkg::PH_COUNT: begin
        if (s_chunks != '0) begin
          if (stream_word == '0) begin
            chunk_end = 1'b1;
          end else begin
            codes_left_next = stream_word;
            phase_next      = rsbd_pkg::PH_CODE;
          end
        end
      end
      rsbd_pkg::PH_CODE: begin
        run_kind_next = kind;
        if (kind == rsbd_pkg::KIND_SKIP) begin
          cursor_next = (skip_sum > SUM_W'(ROW_PIXELS)) ? CUR_W'(ROW_PIXELS)
                                                        : CUR_W'(skip_sum);
          code_end    = 1'b1;
        end else if (kind >= rsbd_pkg::KIND_PAD3) begin
          // padding kinds consume 3, 2 or 1 following words
          run_left_next = rsbd_pkg::COUNT_W'(4'd8 - {1'b0, kind});
          phase_next    = rsbd_pkg::PH_PAD;
        end else if (count == '0) begin
          code_end = 1'b1;
        end else begin
          run_left_next = count;
          phase_next    = rsbd_pkg::PH_RUN;
        end
      end
      rsbd_pkg::PH_RUN: begin
        if (s_cursor < CUR_W'(ROW_PIXELS)) begin
          res.pixel_write = 1'b1;
          res.column      = cur_ext[rsbd_pkg::COL_W-1:0];
          if (operation_mode == rsbd_pkg::MODE_RESTORE) begin
            res.pixel_value = stored_pixel;
          end else begin
            res.pixel_value = rsbd_pkg::blend(s_kind, dest_pixel, stream_word);
            if (operation_mode == rsbd_pkg::MODE_SAVE) begin
              res.save_write  = 1'b1;
              res.saved_value = dest_pixel;
            end
          end
          cursor_next = s_cursor + CUR_W'(1);
        end
        run_left_next = s_run - rsbd_pkg::COUNT_W'(1);
        code_end      = (run_left_next == '0);
      end
      rsbd_pkg::PH_PAD: begin
        run_left_next = s_run - rsbd_pkg::COUNT_W'(1);
        code_end      = (run_left_next == '0);
      end
      default: ;
    endcase

    if (code_end) begin
      phase_next      = rsbd_pkg::PH_CODE;
      run_left_next   = '0;
      codes_left_next = (s_codes != '0) ? s_codes - rsbd_pkg::WORD_W'(1) : '0;
      if (codes_left_next == '0) chunk_end = 1'b1;
    end

    if (chunk_end) begin
      chunks_left_next = (s_chunks != '0) ? s_chunks - rsbd_pkg::CHUNK_W'(1) : '0;
      phase_next       = rsbd_pkg::PH_COUNT;
      codes_left_next  = '0;
      run_left_next    = '0;
      if (chunks_left_next == '0) res.row_done = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= rsbd_pkg::PH_COUNT;
      chunks_left <= '0;
      codes_left  <= '0;
      run_left    <= '0;
      run_kind    <= '0;
      cursor      <= '0;
    end else if (in_fire) begin
      phase       <= phase_next;
      chunks_left <= chunks_left_next;
      codes_left  <= codes_left_next;
      run_left    <= run_left_next;
      run_kind    <= run_kind_next;
      cursor      <= cursor_next;
    end
  end

  // output register with a skid entry behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_full  <= 1'b0;
      skid_full <= 1'b0;
    end else begin
      if (in_fire) begin
        if (out_full && !out_ready) begin
          skid_full <= 1'b1;
        end else begin
          out_full <= 1'b1;
        end
      end else if (out_ready) begin
        if (skid_full) begin
          skid_full <= 1'b0;
        end else begin
          out_full <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      if (out_full && !out_ready) begin
        skid_res <= res;
      end else begin
        out_res <= res;
      end
    end else if (out_ready && skid_full) begin
      out_res <= skid_res;
    end
  end

  assign out_valid   = out_full;
  assign pixel_write = out_res.pixel_write;
  assign column      = out_res.column;
  assign pixel_value = out_res.pixel_value;
  assign save_write  = out_res.save_write;
  assign saved_value = out_res.saved_value;
  assign row_done    = out_res.row_done;

`include "rle_sprite_blend_decoder_assert.svh"

`RSBD_ASSERT(a_skid_behind_out, skid_full, out_full)
`RSBD_ASSERT(a_cursor_in_row, 1'b1, cursor <= CUR_W'(ROW_PIXELS))
`RSBD_ASSERT(a_run_nonzero, phase == rsbd_pkg::PH_RUN || phase == rsbd_pkg::PH_PAD, run_left != '0)
`RSBD_ASSERT(a_save_with_write, out_full && out_res.save_write, out_res.pixel_write)
`RSBD_ASSERT(a_idle_blank, out_full && !out_res.pixel_write, out_res.column == '0 && out_res.pixel_value == '0)
`RSBD_ASSERT_NEXT(a_skid_holds, skid_full && !out_ready, skid_full)

endmodule

`default_nettype wire

FILE: sim/tb_rle_sprite_blend_decoder.sv
// testbench for rle_sprite_blend_decoder: directed and random sprite rows against a row model
`timescale 1ns / 1ps

module tb_rle_sprite_blend_decoder;

  localparam int ROW_LEN = rsbd_pkg::ROW_PIXELS_DEF;
  localparam int STALL_LIMIT = 3000;
  localparam int PHASE_BEATS = 100;
  localparam logic [2:0] ADDR_MODE = {rsbd_pkg::REG_MODE, 2'b00};
  localparam logic [2:0] ADDR_CHUNKS = {rsbd_pkg::REG_CHUNKS, 2'b00};
  localparam logic [rsbd_pkg::MODE_W-1:0] MODE_SPARE = 2'd3;

  logic clk;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_ready;
  logic row_start = 1'b0;
  logic [15:0] stream_word = '0;
  logic [15:0] dest_pixel = '0;
  logic [15:0] stored_pixel = '0;
  logic out_valid;
  logic out_ready = 1'b1;
  logic pixel_write;
  logic [9:0] column;
  logic [15:0] pixel_value;
  logic save_write;
  logic [15:0] saved_value;
  logic row_done;

  rle_sprite_blend_decoder DUT (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready), .row_start(row_start),
    .stream_word(stream_word), .dest_pixel(dest_pixel), .stored_pixel(stored_pixel),
    .out_valid(out_valid), .out_ready(out_ready),
    .pixel_write(pixel_write), .column(column), .pixel_value(pixel_value),
    .save_write(save_write), .saved_value(saved_value), .row_done(row_done)
  );

  // decoder model state and register copies
  logic [rsbd_pkg::MODE_W-1:0] cfg_mode;
  logic [rsbd_pkg::CHUNK_W-1:0] cfg_chunks;
  rsbd_pkg::phase_t dec_phase;
  logic [rsbd_pkg::KIND_W-1:0] run_kind;
  int chunks_left;
  int codes_left;
  int run_left;
  int cursor;

  rsbd_pkg::res_t pending_pixels[$];
  int errors = 0;
  int beats_sent = 0;
  int results_seen = 0;
  int rows_seen = 0;
  int burst_left = 0;
  int idle_cycles = 0;
  bit steady_feed = 1'b0;
  logic [9:0] rx_cycle = '0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic void reset_decoder_model();
    cfg_mode = rsbd_pkg::MODE_DRAW;
    cfg_chunks = 7'd1;
    dec_phase = rsbd_pkg::PH_COUNT;
    run_kind = rsbd_pkg::KIND_SKIP;
    chunks_left = 0;
    codes_left = 0;
    run_left = 0;
    cursor = 0;
  endfunction

  function automatic bit close_chunk();
    if (chunks_left > 0) chunks_left--;
    dec_phase = rsbd_pkg::PH_COUNT;
    codes_left = 0;
    run_left = 0;
    return chunks_left == 0;
  endfunction

  function automatic bit close_code();
    dec_phase = rsbd_pkg::PH_CODE;
    run_left = 0;
    if (codes_left > 0) codes_left--;
    if (codes_left == 0) return close_chunk();
    return 1'b0;
  endfunction

  function automatic logic [15:0] mix_rgb565(input logic [rsbd_pkg::KIND_W-1:0] kind,
                                             input logic [15:0] d, input logic [15:0] s);
    int dq, sq, v;
    dq = int'(d & rsbd_pkg::MASK_QUARTER);
    sq = int'(s & rsbd_pkg::MASK_QUARTER);
    case (kind)
      rsbd_pkg::KIND_B25: v = (3 * dq + sq) >> 2;
      rsbd_pkg::KIND_B50: v = (int'(d & rsbd_pkg::MASK_HALF) +
                               int'(s & rsbd_pkg::MASK_HALF)) >> 1;
      rsbd_pkg::KIND_B75: v = (dq + 3 * sq) >> 2;
      default:            v = int'(s);
    endcase
    return v[15:0];
  endfunction

  function automatic rsbd_pkg::res_t decode_word(input logic start, input logic [15:0] word,
                                                 input logic [15:0] dpix,
                                                 input logic [15:0] spix);
    rsbd_pkg::res_t r;
    logic [rsbd_pkg::KIND_W-1:0] kind;
    int count;
    r = '0;
    kind = word[15:13];
    count = int'(word[12:0]);
    if (start) begin
      chunks_left = (cfg_chunks == 0) ? 1 : int'(cfg_chunks);
      dec_phase = rsbd_pkg::PH_COUNT;
      codes_left = 0;
      run_left = 0;
      run_kind = rsbd_pkg::KIND_SKIP;
      cursor = 0;
    end
    case (dec_phase)
      rsbd_pkg::PH_COUNT: begin
        // no open row: word is swallowed
        if (chunks_left != 0) begin
          if (word == 16'd0) begin
            r.row_done = close_chunk();
          end else begin
            codes_left = int'(word);
            dec_phase = rsbd_pkg::PH_CODE;
          end
        end
      end
      rsbd_pkg::PH_CODE: begin
        run_kind = kind;
        if (kind == rsbd_pkg::KIND_SKIP) begin
          cursor = (cursor + count > ROW_LEN) ? ROW_LEN : cursor + count;
          r.row_done = close_code();
        end else if (kind >= rsbd_pkg::KIND_PAD3) begin
          run_left = 8 - int'(kind);
          dec_phase = rsbd_pkg::PH_PAD;
        end else if (count == 0) begin
          r.row_done = close_code();
        end else begin
          run_left = count;
          dec_phase = rsbd_pkg::PH_RUN;
        end
      end
      rsbd_pkg::PH_RUN: begin
        if (cursor < ROW_LEN) begin
          r.pixel_write = 1'b1;
          r.column = cursor[9:0];
          if (cfg_mode == rsbd_pkg::MODE_RESTORE) begin
            r.pixel_value = spix;
          end else begin
            r.pixel_value = mix_rgb565(run_kind, dpix, word);
            if (cfg_mode == rsbd_pkg::MODE_SAVE) begin
              r.save_write = 1'b1;
              r.saved_value = dpix;
            end
          end
          cursor++;
        end
        run_left--;
        if (run_left == 0) r.row_done = close_code();
      end
      default: begin
        run_left--;
        if (run_left == 0) r.row_done = close_code();
      end
    endcase
    return r;
  endfunction

  function automatic logic [15:0] rand16();
    return 16'($urandom);
  endfunction

  task automatic send_beat(input logic start, input logic [15:0] word,
                           input logic [15:0] dpix, input logic [15:0] spix);
    if (!steady_feed) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 20);
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end
      burst_left--;
    end
    pending_pixels.push_back(decode_word(start, word, dpix, spix));
    in_valid <= 1'b1;
    row_start <= start;
    stream_word <= word;
    dest_pixel <= dpix;
    stored_pixel <= spix;
    do @(posedge clk); while (!in_ready);
    beats_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    if (addr == ADDR_MODE) cfg_mode = value[rsbd_pkg::MODE_W-1:0];
    else cfg_chunks = value[rsbd_pkg::CHUNK_W-1:0];
  endtask

  task automatic set_config(input logic [rsbd_pkg::MODE_W-1:0] mode, input int chunks);
    drain();
    write_reg(ADDR_MODE, 32'(mode));
    write_reg(ADDR_CHUNKS, 32'(chunks));
  endtask

  task automatic send_code();
    logic [rsbd_pkg::KIND_W-1:0] kind;
    int count, words;
    kind = 3'($urandom_range(0, 7));
    if (kind == rsbd_pkg::KIND_SKIP)
      count = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 8191)
                                          : $urandom_range(0, 40);
    else if (kind >= rsbd_pkg::KIND_PAD3)
      count = $urandom_range(0, 8191);
    else
      count = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 6);
    send_beat(1'b0, {kind, 13'(count)}, rand16(), rand16());
    if (kind >= rsbd_pkg::KIND_PAD3) words = 8 - int'(kind);
    else if (kind == rsbd_pkg::KIND_SKIP) words = 0;
    else words = count;
    repeat (words) send_beat(1'b0, rand16(), rand16(), rand16());
  endtask

  // a broken row may carry a wild code count and is cut off by the next row_start
  task automatic send_row(input bit broken);
    int n_chunks, n_codes;
    logic [15:0] count_word;
    n_chunks = (cfg_chunks == 0) ? 1 : int'(cfg_chunks);
    for (int c = 0; c < n_chunks; c++) begin
      if (broken && $urandom_range(0, 2) == 0) count_word = rand16();
      else if ($urandom_range(0, 4) == 0) count_word = 16'd0;
      else count_word = 16'($urandom_range(1, 4));
      send_beat(c == 0, count_word, rand16(), rand16());
      n_codes = (count_word > 4) ? 4 : int'(count_word);
      for (int k = 0; k < n_codes; k++) begin
        if (broken && $urandom_range(0, 3) == 0) return;
        send_code();
      end
      if (count_word > 4) return;
    end
  endtask

  task automatic test_no_open_row();
    send_beat(1'b0, 16'hffff, 16'hffff, 16'hffff);
  endtask

  task automatic test_blend_kinds();
    send_beat(1'b1, 16'd6, 16'h0000, 16'h0000);
    send_beat(1'b0, {rsbd_pkg::KIND_B25, 13'd1}, rand16(), rand16());
    send_beat(1'b0, 16'h0000, 16'hffff, 16'hffff);
    send_beat(1'b0, {rsbd_pkg::KIND_B50, 13'd1}, rand16(), rand16());
    send_beat(1'b0, 16'hffff, 16'h0000, 16'h0000);
    send_beat(1'b0, {rsbd_pkg::KIND_B75, 13'd1}, rand16(), rand16());
    send_beat(1'b0, 16'hffff, 16'hffff, 16'h0000);
    send_beat(1'b0, {rsbd_pkg::KIND_COPY, 13'd1}, rand16(), rand16());
    send_beat(1'b0, 16'ha5a5, 16'h5a5a, 16'h3c3c);
    // empty copy run
    send_beat(1'b0, {rsbd_pkg::KIND_COPY, 13'd0}, rand16(), rand16());
    send_beat(1'b0, {rsbd_pkg::KIND_PAD3, 13'h1fff}, rand16(), rand16());
    repeat (3) send_beat(1'b0, rand16(), rand16(), rand16());
    // row already finished
    send_beat(1'b0, 16'h0000, 16'h0000, 16'h0000);
  endtask

  task automatic test_save_and_saturation();
    set_config(rsbd_pkg::MODE_SAVE, 2);
    send_beat(1'b1, 16'd2, rand16(), rand16());
    send_beat(1'b0, {rsbd_pkg::KIND_SKIP, 13'd1022}, rand16(), rand16());
    send_beat(1'b0, {rsbd_pkg::KIND_COPY, 13'd3}, rand16(), rand16());
    // third pixel lands past the row end
    repeat (3) send_beat(1'b0, rand16(), rand16(), rand16());
    send_beat(1'b0, 16'd0, rand16(), rand16());
  endtask

  task automatic test_restore();
    set_config(rsbd_pkg::MODE_RESTORE, 1);
    send_beat(1'b1, 16'd1, rand16(), rand16());
    send_beat(1'b0, {rsbd_pkg::KIND_B50, 13'd1}, rand16(), rand16());
    send_beat(1'b0, rand16(), rand16(), 16'h1234);
  endtask

  task automatic test_chunk_register_edges();
    // spare mode value and zero chunks register
    set_config(MODE_SPARE, 0);
    send_beat(1'b1, 16'd0, rand16(), rand16());
  endtask

  task automatic test_random_rows();
    logic [rsbd_pkg::MODE_W-1:0] phase_modes [8] = '{
      rsbd_pkg::MODE_RESTORE, rsbd_pkg::MODE_SAVE, MODE_SPARE, rsbd_pkg::MODE_DRAW,
      rsbd_pkg::MODE_SAVE, rsbd_pkg::MODE_RESTORE, rsbd_pkg::MODE_DRAW, MODE_SPARE};
    int phase_chunks [8] = '{1, 3, 0, 64, 0, 2, 1, 4};
    int chunks, first_beat;
    for (int p = 0; p < 8; p++) begin
      chunks = (p == 4) ? $urandom_range(2, 12) : phase_chunks[p];
      set_config(phase_modes[p], chunks);
      steady_feed = (p % 3 == 1);
      first_beat = beats_sent;
      while (beats_sent - first_beat < PHASE_BEATS) begin
        send_row($urandom_range(0, 9) == 0);
        if ($urandom_range(0, 3) == 0)
          repeat ($urandom_range(1, 2)) send_beat(1'b0, rand16(), rand16(), rand16());
      end
    end
    steady_feed = 1'b0;
  endtask

  // receiver stall pattern: free running, coin flip, mostly stalled, long stalls
  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 10'd1;
    case (rx_cycle[9:8])
      2'd0: out_ready <= 1'b1;
      2'd1: out_ready <= 1'($urandom_range(0, 1));
      2'd2: out_ready <= ($urandom_range(0, 3) == 0);
      default: out_ready <= (rx_cycle[4:0] >= 5'd24);
    endcase
  end

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin : check_results
    rsbd_pkg::res_t want;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (pending_pixels.size() == 0) begin
        $error("result beat with nothing pending");
        errors++;
      end else begin
        want = pending_pixels.pop_front();
        check_field("pixel_write", 16'(want.pixel_write), 16'(pixel_write));
        check_field("column", 16'(want.column), 16'(column));
        check_field("pixel_value", want.pixel_value, pixel_value);
        check_field("save_write", 16'(want.save_write), 16'(save_write));
        check_field("saved_value", want.saved_value, saved_value);
        check_field("row_done", 16'(want.row_done), 16'(row_done));
        if (want.row_done) rows_seen++;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("tb_rle_sprite_blend_decoder: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    reset_decoder_model();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_no_open_row();
    test_blend_kinds();
    test_save_and_saturation();
    test_restore();
    test_chunk_register_edges();
    test_random_rows();
    drain();
    repeat (8) @(posedge clk);
    $display("covered %0d input beats, %0d results, %0d finished rows", beats_sent,
             results_seen, rows_seen);
    $display("all four mode values, chunk counts 0 to 64, blends, padding and cursor clamp");
    if (errors == 0) begin
      $display("tb_rle_sprite_blend_decoder: clean");
    end else begin
      $display("tb_rle_sprite_blend_decoder: errors");
    end
    $finish;
  end

endmodule
